@@ sv/iol_pkg.sv @@
// Package with constants, codes and payload types of the indexed ordered list unit.
package iol_pkg;

    localparam int CAPACITY = 64;
    localparam int ELEM_W   = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        ACT_GET    = 3'd0,
        ACT_MODIFY = 3'd1,
        ACT_INSERT = 3'd2,
        ACT_DELETE = 3'd3,
        ACT_APPEND = 3'd4,
        ACT_POP    = 3'd5,
        ACT_SEARCH = 3'd6,
        ACT_CLEAR  = 3'd7
    } t_action;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        t_action            action;
        logic [5:0]         index;
        logic signed [31:0] value;
    } t_in_item;

    typedef struct packed {
        t_status            status;
        logic signed [31:0] read_value;
        logic               found;
        logic [5:0]         position;
        logic [6:0]         count;
    } t_out_item;

    typedef struct packed {
        logic             go;
        t_action          act;
        logic [IDX_W-1:0] idx;
        logic [CNT_W-1:0] cnt;
    } t_cell_ctl;

endpackage

@@ sv/iol_cell.sv @@
// One storage cell of the list chain: holds one element and shifts with its neighbors.
module iol_cell (
    input  logic                      i_clk,
    input  iol_pkg::t_cell_ctl        i_ctl,
    input  logic [iol_pkg::IDX_W-1:0] i_pos,
    input  logic signed [31:0]        i_value,
    input  logic signed [31:0]        i_prev,
    input  logic signed [31:0]        i_next,
    output logic signed [31:0]        o_data,
    output logic                      o_match
);
    import iol_pkg::*;

    logic signed [ELEM_W-1:0] r_data;
    logic signed [ELEM_W-1:0] n_data;
    logic [CNT_W-1:0]         pos_ext;
    logic [CNT_W-1:0]         idx_ext;

    assign pos_ext = CNT_W'(i_pos);
    assign idx_ext = CNT_W'(i_ctl.idx);

    always_comb begin
        n_data = r_data;
        if (i_ctl.go) begin
            case (i_ctl.act)
                ACT_MODIFY: begin
                    if (pos_ext == idx_ext) n_data = i_value;
                end
                ACT_INSERT: begin
                    if (pos_ext > idx_ext) n_data = i_prev;
                    else if (pos_ext == idx_ext) n_data = i_value;
                end
                ACT_DELETE: begin
                    if ((pos_ext >= idx_ext) && ((pos_ext + CNT_W'(1)) < i_ctl.cnt))
                        n_data = i_next;
                end
                ACT_APPEND: begin
                    if (pos_ext == i_ctl.cnt) n_data = i_value;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data  = r_data;
    assign o_match = (r_data == i_value) && (pos_ext < i_ctl.cnt);

endmodule

@@ sv/indexed_ordered_list_unit.sv @@
// Top level of the indexed ordered list unit: a chain of element cells and its controller.
//
// Requests arrive on the input channel (i_in_valid, o_in_ready, i_in_item) and
// one result per request leaves on the output channel (o_out_valid, i_out_ready,
// o_out_item). Each request selects get, modify, insert, delete, append, pop,
// search or clear on a list of up to CAPACITY elements held in a row of cells.
// On acceptance every cell shifts, writes or compares at once.
// The next cycle encodes the last matching cell and loads the result register,
// so the result is valid in the output state that follows the encode state.
// One request is in flight at a time: o_in_ready is high only while no result
// is pending, so a new request waits until the last result has been taken.
// A stalled receiver holds the result and blocks new requests until it is taken.
// Reset empties the list and drops any pending result; element storage is not
// cleared, and only entries below the count are ever read.
module indexed_ordered_list_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  iol_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output iol_pkg::t_out_item o_out_item
);
    import iol_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_ENC  = 3'b010,
        S_OUT  = 3'b100
    } t_state;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [CAPACITY-1:0] r_match;
    t_status            r_status, n_status;
    logic signed [31:0] r_rd, n_rd;
    logic               r_search;
    t_out_item          r_out;

    logic               accept;
    t_cell_ctl          ctl;
    logic [IDX_W-1:0]   idx;
    logic [IDX_W-1:0]   rd_idx;
    logic               in_rng;
    logic               full;
    logic signed [31:0] rd_mux;
    logic               found;
    logic [IDX_W-1:0]   last_pos;

    logic signed [31:0]  cell_data [CAPACITY];
    logic [CAPACITY-1:0] cell_match;

    assign accept = i_in_valid && o_in_ready;
    assign idx    = IDX_W'(i_in_item.index);
    assign in_rng = CNT_W'(idx) < r_cnt;
    assign full   = r_cnt == CNT_W'(CAPACITY);
    assign rd_idx = (i_in_item.action == ACT_POP) ? IDX_W'(r_cnt - CNT_W'(1)) : idx;

    always_comb begin
        n_status = ST_OK;
        n_cnt    = r_cnt;
        case (i_in_item.action)
            ACT_GET, ACT_MODIFY: begin
                if (!in_rng) n_status = ST_RANGE;
            end
            ACT_INSERT: begin
                if (full) n_status = ST_FULL;
                else if (!in_rng) n_status = ST_RANGE;
                else n_cnt = r_cnt + CNT_W'(1);
            end
            ACT_DELETE: begin
                if (!in_rng) n_status = ST_RANGE;
                else n_cnt = r_cnt - CNT_W'(1);
            end
            ACT_APPEND: begin
                if (full) n_status = ST_FULL;
                else n_cnt = r_cnt + CNT_W'(1);
            end
            ACT_POP: begin
                if (r_cnt == '0) n_status = ST_RANGE;
                else n_cnt = r_cnt - CNT_W'(1);
            end
            ACT_CLEAR: begin
                n_cnt = '0;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        rd_mux = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (rd_idx == IDX_W'(i)) rd_mux = rd_mux | cell_data[i];
        end
    end

    always_comb begin
        n_rd = '0;
        if (n_status == ST_OK) begin
            case (i_in_item.action)
                ACT_GET, ACT_DELETE, ACT_POP: n_rd = rd_mux;
                default: n_rd = '0;
            endcase
        end
    end

    assign ctl.go  = accept && (n_status == ST_OK);
    assign ctl.act = i_in_item.action;
    assign ctl.idx = idx;
    assign ctl.cnt = r_cnt;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [31:0] prev_d;
        logic signed [31:0] next_d;
        if (g == 0) begin : g_first
            assign prev_d = '0;
        end else begin : g_mid_prev
            assign prev_d = cell_data[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign next_d = cell_data[g];
        end else begin : g_mid_next
            assign next_d = cell_data[g+1];
        end
        iol_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (ctl),
            .i_pos   (IDX_W'(g)),
            .i_value (i_in_item.value),
            .i_prev  (prev_d),
            .i_next  (next_d),
            .o_data  (cell_data[g]),
            .o_match (cell_match[g])
        );
    end

    always_comb begin
        found    = 1'b0;
        last_pos = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (r_match[i]) begin
                found    = 1'b1;
                last_pos = IDX_W'(i);
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (accept) n_state = S_ENC;
            S_ENC:  n_state = S_OUT;
            S_OUT:  if (i_out_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (accept) r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_match  <= cell_match;
            r_status <= n_status;
            r_rd     <= n_rd;
            r_search <= (i_in_item.action == ACT_SEARCH);
        end
        if (r_state == S_ENC) begin
            r_out.status     <= r_status;
            r_out.read_value <= r_rd;
            r_out.found      <= r_search && found;
            r_out.position   <= (r_search && found) ? 6'(last_pos) : 6'd0;
            r_out.count      <= 7'(r_cnt);
        end
    end

    assign o_in_ready  = r_state == S_IDLE;
    assign o_out_valid = r_state == S_OUT;
    assign o_out_item  = r_out;

`ifndef ASSERT_OFF
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(CAPACITY))
        else $error("element count above capacity");

    a_accept_enc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_ENC))
        else $error("accepted request did not enter encode state");

    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.found) |-> (o_out_item.status == ST_OK))
        else $error("search match with error status");

    a_cnt_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!accept && $past(i_rst_n)) |=> $stable(r_cnt))
        else $error("count changed without a request");
`endif

endmodule
